FILE: rtl/gte_pkg.sv
// gte_pkg: constants and types shared by the geodetic to ecef datapath
// no dependencies; used by gte_term, gte_sincos and geodetic_to_ecef
package gte_pkg;

    localparam logic [63:0] ONE_Q62      = 64'h4000_0000_0000_0000;
    localparam logic [63:0] THREE_Q62    = 64'hC000_0000_0000_0000;
    localparam logic [63:0] PI_Q62       = 64'hC90F_DAA2_2168_C235;
    localparam logic [63:0] PHASE_K      = 64'd1311768467464;
    localparam logic [63:0] E2_Q62       = 64'd30872378602568713;
    localparam logic [63:0] ONE_MINUS_E2 = ONE_Q62 - E2_Q62;
    localparam logic [63:0] SEMI_MAJOR   = 64'd6378137000;
    localparam logic [63:0] OUT_LIMIT    = 64'd8000000000;
    localparam logic [37:0] OCT_SPAN     = 38'h20_0000_0000;
    localparam logic [38:0] QUAD_SPAN    = 39'h40_0000_0000;

    // sine and cosine magnitudes with their sign flags
    typedef struct packed {
        logic [63:0] s;
        logic        sn;
        logic [63:0] c;
        logic        cn;
    } trig_t;

endpackage

FILE: rtl/gte_delay.sv
// gte_delay: fixed-length register line for payload alignment
// no dependencies
module gte_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        line_reg[0] <= d;
        for (int i = 1; i < DEPTH; i++)
        begin
            line_reg[i] <= line_reg[i-1];
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

FILE: rtl/gte_mul.sv
// gte_mul: two-stage 64x64 multiply, rounded half up and shifted right
// stage one holds four 32x32 partial products; no dependencies
module gte_mul #(
    parameter int SHIFT = 62
) (
    input  logic        clk,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    localparam int SW = (SHIFT + 64 > 128) ? SHIFT + 64 : 128;
    localparam logic [SW-1:0] RND = SW'(1) << (SHIFT - 1);

    logic [63:0]   p00_reg, p01_reg, p10_reg, p11_reg;
    logic [63:0]   p_reg;
    logic [SW-1:0] sum;

    always_ff @(posedge clk)
    begin
        p00_reg <= 64'(a[31:0]) * 64'(b[31:0]);
        p01_reg <= 64'(a[31:0]) * 64'(b[63:32]);
        p10_reg <= 64'(a[63:32]) * 64'(b[31:0]);
        p11_reg <= 64'(a[63:32]) * 64'(b[63:32]);
    end

    assign sum = SW'(p00_reg) + (SW'(p01_reg) << 32) + (SW'(p10_reg) << 32)
               + (SW'(p11_reg) << 64) + RND;

    always_ff @(posedge clk)
    begin
        p_reg <= sum[SHIFT +: 64];
    end

    assign p = p_reg;

endmodule

FILE: rtl/gte_term.sv
// gte_term: one series cell, t_out = 1 - floor(x2 * t_in / DIVISOR)
// uses gte_mul, gte_delay and gte_pkg
module gte_term #(
    parameter int DIVISOR = 6
) (
    input  logic        clk,
    input  logic [63:0] x2_in,
    input  logic [63:0] t_in,
    output logic [63:0] x2_out,
    output logic [63:0] t_out
);

    logic [63:0] v;
    logic [63:0] quot;

    gte_mul #(.SHIFT(62)) u_prod (.clk(clk), .a(x2_in), .b(t_in), .p(v));

    gte_delay #(.WIDTH(64), .DEPTH(5)) u_x2 (.clk(clk), .d(x2_in), .q(x2_out));

    if ((DIVISOR & (DIVISOR - 1)) == 0)
    begin : g_pow2
        localparam int LOG = $clog2(DIVISOR);
        logic [63:0] vd;

        gte_delay #(.WIDTH(64), .DEPTH(3)) u_vd (.clk(clk), .d(v), .q(vd));
        assign quot = vd >> LOG;
    end
    else
    begin : g_recip
        localparam int LOG = $clog2(DIVISOR + 1) - 1;
        localparam int SH  = 64 + LOG;
        localparam logic [127:0] M_WIDE =
            ((128'd1 << SH) + 128'(DIVISOR / 2)) / 128'(DIVISOR);
        localparam logic [63:0] RECIP = M_WIDE[63:0];

        logic [63:0] q0;
        logic [63:0] vd;
        logic [71:0] back;
        logic [63:0] q_reg;

        gte_mul #(.SHIFT(SH)) u_recip (.clk(clk), .a(v), .b(RECIP), .p(q0));
        gte_delay #(.WIDTH(64), .DEPTH(2)) u_vd (.clk(clk), .d(v), .q(vd));

        // estimate is exact or one too high
        assign back = 72'(q0) * 72'(DIVISOR);

        always_ff @(posedge clk)
        begin
            q_reg <= (back > 72'(vd)) ? q0 - 64'd1 : q0;
        end

        assign quot = q_reg;
    end

    assign t_out = gte_pkg::ONE_Q62 - quot;

endmodule

FILE: rtl/gte_sincos.sv
// gte_sincos: angle in 1e-7 degree to sine and cosine magnitudes and signs
// phase, octant fold, chains of gte_term cells; uses gte_mul, gte_delay, gte_pkg
module gte_sincos (
    input  logic                clk,
    input  logic [63:0]         ang,
    output gte_pkg::trig_t      trig
);

    logic [63:0] mag;
    logic [63:0] ph;
    logic        neg_d;
    logic [39:0] p40;
    logic [37:0] f;
    logic [37:0] r;
    logic [63:0] r_reg;
    logic [1:0]  quad_reg;
    logic        swap_reg;
    logic [1:0]  quad_d;
    logic        swap_d;
    logic [63:0] x, x2, xd;
    logic [63:0] s_raw, s_al;
    logic [63:0] st, ct;
    gte_pkg::trig_t trig_reg;

    logic [63:0] sx2 [8];
    logic [63:0] sts [8];
    logic [63:0] cx2 [9];
    logic [63:0] cts [9];

    assign mag = ang[63] ? 64'd0 - ang : ang;

    gte_mul #(.SHIFT(32)) u_phase (.clk(clk), .a(mag), .b(gte_pkg::PHASE_K), .p(ph));
    gte_delay #(.WIDTH(1), .DEPTH(2)) u_neg (.clk(clk), .d(ang[63]), .q(neg_d));

    assign p40 = neg_d ? 40'd0 - ph[39:0] : ph[39:0];
    assign f   = p40[37:0];
    assign r   = (f <= gte_pkg::OCT_SPAN) ? f : 38'(gte_pkg::QUAD_SPAN - 39'(f));

    always_ff @(posedge clk)
    begin
        r_reg    <= 64'(r);
        quad_reg <= p40[39:38];
        swap_reg <= (f > gte_pkg::OCT_SPAN);
    end

    gte_mul #(.SHIFT(39)) u_rad (.clk(clk), .a(r_reg), .b(gte_pkg::PI_Q62), .p(x));
    gte_mul #(.SHIFT(62)) u_sq  (.clk(clk), .a(x), .b(x), .p(x2));

    // sine series, k = 7 down to 1
    assign sx2[0] = x2;
    assign sts[0] = gte_pkg::ONE_Q62;
    for (genvar i = 0; i < 7; i++)
    begin : g_sin
        localparam int K = 7 - i;
        if (i < 6)
        begin : g_mid
            gte_term #(.DIVISOR(2 * K * (2 * K + 1))) u_term (
                .clk(clk), .x2_in(sx2[i]), .t_in(sts[i]),
                .x2_out(sx2[i+1]), .t_out(sts[i+1]));
        end
        else
        begin : g_last
            logic [63:0] x2_unused;
            gte_term #(.DIVISOR(2 * K * (2 * K + 1))) u_term (
                .clk(clk), .x2_in(sx2[i]), .t_in(sts[i]),
                .x2_out(x2_unused), .t_out(sts[i+1]));
            assign sx2[i+1] = x2_unused;
        end
    end

    // cosine series, k = 8 down to 1
    assign cx2[0] = x2;
    assign cts[0] = gte_pkg::ONE_Q62;
    for (genvar i = 0; i < 8; i++)
    begin : g_cos
        localparam int K = 8 - i;
        gte_term #(.DIVISOR((2 * K - 1) * 2 * K)) u_term (
            .clk(clk), .x2_in(cx2[i]), .t_in(cts[i]),
            .x2_out(cx2[i+1]), .t_out(cts[i+1]));
    end

    gte_delay #(.WIDTH(64), .DEPTH(37)) u_xd (.clk(clk), .d(x), .q(xd));
    gte_mul #(.SHIFT(62)) u_sfin (.clk(clk), .a(xd), .b(sts[7]), .p(s_raw));
    gte_delay #(.WIDTH(64), .DEPTH(3)) u_sal (.clk(clk), .d(s_raw), .q(s_al));

    gte_delay #(.WIDTH(3), .DEPTH(44)) u_flags (
        .clk(clk), .d({quad_reg, swap_reg}), .q({quad_d, swap_d}));

    // folded octant swaps sine and cosine
    assign st = swap_d ? cts[8] : s_al;
    assign ct = swap_d ? s_al : cts[8];

    always_ff @(posedge clk)
    begin
        case (quad_d)
            2'd0:
            begin
                trig_reg <= '{s: st, sn: 1'b0, c: ct, cn: 1'b0};
            end
            2'd1:
            begin
                trig_reg <= '{s: ct, sn: 1'b0, c: st, cn: 1'b1};
            end
            2'd2:
            begin
                trig_reg <= '{s: st, sn: 1'b1, c: ct, cn: 1'b1};
            end
            default:
            begin
                trig_reg <= '{s: ct, sn: 1'b1, c: st, cn: 1'b0};
            end
        endcase
    end

    assign trig = trig_reg;

endmodule

FILE: rtl/geodetic_to_ecef.sv
// geodetic_to_ecef: wgs84 geodetic point to earth-centred earth-fixed millimetres
// uses gte_sincos, gte_term, gte_mul, gte_delay and gte_pkg
//
// channel   direction  signals                          handshake
// request   in         latitude, longitude, altitude    start (busy is always low)
// result    out        ecef_x, ecef_y, ecef_z           done, one cycle per result
//
// a request may be given every cycle; the time until its result appears
// is set by the chain of series cells and the five newton steps,
// each multiply being split over two register stages
// reset clears only the result strobe line; the datapath needs none
// results cannot be held off, and nothing in the block waits on them
module geodetic_to_ecef (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [30:0] latitude,
    input  logic signed [31:0] longitude,
    input  logic signed [27:0] altitude,
    output logic               done,
    output logic signed [33:0] ecef_x,
    output logic signed [33:0] ecef_y,
    output logic signed [33:0] ecef_z
);

    localparam int VLD_DEPTH = 88;

    gte_pkg::trig_t lat_t, lon_t;
    logic [63:0] sl2, esl2, w;
    logic [63:0] ny [6];
    logic [63:0] nw [5];
    logic [63:0] n, nz, h84, h86, r, rz;
    logic [63:0] cl84, co86, so86, sl86, m;
    logic [63:0] mx, my, mz;
    logic [27:0] alt84;
    logic [2:0]  sgn88;
    logic [VLD_DEPTH-1:0] vld_reg;
    logic        done_reg;
    logic [33:0] x_reg, y_reg, z_reg;

    function automatic logic [33:0] finish(input logic [63:0] mag, input logic neg);
        logic [63:0] mm;
        logic [63:0] sv;
        mm = (mag + 64'd524288) >> 20;
        if (mm > gte_pkg::OUT_LIMIT)
        begin
            mm = gte_pkg::OUT_LIMIT;
        end
        sv = neg ? 64'd0 - mm : mm;
        return sv[33:0];
    endfunction

    assign busy = 1'b0;

    gte_sincos u_lat (.clk(clk), .ang({{33{latitude[30]}}, latitude}), .trig(lat_t));
    gte_sincos u_lon (.clk(clk), .ang({{32{longitude[31]}}, longitude}), .trig(lon_t));

    gte_mul #(.SHIFT(62)) u_sl2 (.clk(clk), .a(lat_t.s), .b(lat_t.s), .p(sl2));
    gte_mul #(.SHIFT(62)) u_e2 (.clk(clk), .a(gte_pkg::E2_Q62), .b(sl2), .p(esl2));
    assign w = gte_pkg::ONE_Q62 - esl2;

    // newton steps towards 1/sqrt(w)
    assign ny[0] = gte_pkg::ONE_Q62;
    assign nw[0] = w;
    for (genvar i = 0; i < 5; i++)
    begin : g_newton
        logic [63:0] yy, wd, wyy, yd, tcorr;

        gte_mul #(.SHIFT(62)) u_yy (.clk(clk), .a(ny[i]), .b(ny[i]), .p(yy));
        gte_delay #(.WIDTH(64), .DEPTH(2)) u_wd (.clk(clk), .d(nw[i]), .q(wd));
        gte_mul #(.SHIFT(62)) u_wyy (.clk(clk), .a(wd), .b(yy), .p(wyy));
        gte_delay #(.WIDTH(64), .DEPTH(4)) u_yd (.clk(clk), .d(ny[i]), .q(yd));
        assign tcorr = gte_pkg::THREE_Q62 - wyy;
        gte_mul #(.SHIFT(63)) u_y (.clk(clk), .a(yd), .b(tcorr), .p(ny[i+1]));

        if (i < 4)
        begin : g_wnext
            gte_delay #(.WIDTH(64), .DEPTH(4)) u_wn (.clk(clk), .d(wd), .q(nw[i+1]));
        end
    end

    gte_mul #(.SHIFT(42)) u_n (.clk(clk), .a(gte_pkg::SEMI_MAJOR), .b(ny[5]), .p(n));
    gte_mul #(.SHIFT(62)) u_nz (.clk(clk), .a(n), .b(gte_pkg::ONE_MINUS_E2), .p(nz));

    gte_delay #(.WIDTH(28), .DEPTH(84)) u_alt (.clk(clk), .d(altitude), .q(alt84));
    assign h84 = {{36{alt84[27]}}, alt84} << 20;
    gte_delay #(.WIDTH(64), .DEPTH(2)) u_h86 (.clk(clk), .d(h84), .q(h86));
    assign r  = n + h84;
    assign rz = nz + h86;

    gte_delay #(.WIDTH(64), .DEPTH(36)) u_cl (.clk(clk), .d(lat_t.c), .q(cl84));
    gte_delay #(.WIDTH(64), .DEPTH(38)) u_co (.clk(clk), .d(lon_t.c), .q(co86));
    gte_delay #(.WIDTH(64), .DEPTH(38)) u_so (.clk(clk), .d(lon_t.s), .q(so86));
    gte_delay #(.WIDTH(64), .DEPTH(38)) u_sl (.clk(clk), .d(lat_t.s), .q(sl86));
    gte_delay #(.WIDTH(3), .DEPTH(40)) u_sgn (
        .clk(clk),
        .d({lat_t.cn ^ lon_t.cn, lat_t.cn ^ lon_t.sn, lat_t.sn}),
        .q(sgn88));

    gte_mul #(.SHIFT(62)) u_m  (.clk(clk), .a(r), .b(cl84), .p(m));
    gte_mul #(.SHIFT(62)) u_mx (.clk(clk), .a(m), .b(co86), .p(mx));
    gte_mul #(.SHIFT(62)) u_my (.clk(clk), .a(m), .b(so86), .p(my));
    gte_mul #(.SHIFT(62)) u_mz (.clk(clk), .a(rz), .b(sl86), .p(mz));

    always_ff @(posedge clk)
    begin
        x_reg <= finish(mx, sgn88[2]);
        y_reg <= finish(my, sgn88[1]);
        z_reg <= finish(mz, sgn88[0]);
    end

    // request strobe follows the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[VLD_DEPTH-2:0], start & ~busy};
            done_reg <= vld_reg[VLD_DEPTH-1];
        end
    end

    assign done   = done_reg;
    assign ecef_x = x_reg;
    assign ecef_y = y_reg;
    assign ecef_z = z_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 89))
        else $error("result without matching request");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed(ecef_x) <= 34'sd8000000000 && $signed(ecef_x) >= -34'sd8000000000
              && $signed(ecef_y) <= 34'sd8000000000 && $signed(ecef_y) >= -34'sd8000000000
              && $signed(ecef_z) <= 34'sd8000000000 && $signed(ecef_z) >= -34'sd8000000000))
        else $error("result beyond saturation limit");

    a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld_reg) <= VLD_DEPTH && (vld_reg[0] == $past(start & ~busy)))
        else $error("strobe line lost a request");
`endif

endmodule

FILE: tb/sv/geodetic_to_ecef_checker.sv
`timescale 1ns / 1ps
// geodetic_to_ecef_checker: watches the request and result ports of geodetic_to_ecef,
// works out the expected ecef point of each request and compares; depends on nothing else
module geodetic_to_ecef_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [30:0] latitude,
    input  logic signed [31:0] longitude,
    input  logic signed [27:0] altitude,
    input  logic               done,
    input  logic signed [33:0] ecef_x,
    input  logic signed [33:0] ecef_y,
    input  logic signed [33:0] ecef_z,
    output int                 fail_count,
    output int                 pending
);

    localparam logic [63:0] UNIT_Q62   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] PI_FIX     = 64'hC90F_DAA2_2168_C235;
    localparam logic [63:0] TURN_SCALE = 64'd1311768467464;
    localparam logic [63:0] ECC_SQ     = 64'd30872378602568713;
    localparam logic [63:0] AXIS_MM    = 64'd6378137000;
    localparam logic [63:0] SAT_MM     = 64'd8000000000;
    localparam logic [39:0] QUARTER    = 40'h40_0000_0000;
    localparam logic [39:0] EIGHTH     = 40'h20_0000_0000;

    typedef struct packed {
        logic [33:0] x;
        logic [33:0] y;
        logic [33:0] z;
    } ecef_pt_t;

    ecef_pt_t expected_points[$];

    function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                              input int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (sh - 1));
        return 64'(p >> sh);
    endfunction

    function automatic logic [39:0] angle_phase(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [39:0] p;
        mag = v < 0 ? -v : v;
        p = 40'(mul_round(mag, TURN_SCALE, 32));
        if (v < 0)
            p = -p;
        return p;
    endfunction

    // series sine and cosine, r at most one eighth of a turn
    task automatic eighth_sincos(input logic [63:0] r, output logic [63:0] s,
                                 output logic [63:0] c);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x = mul_round(r, PI_FIX, 39);
        x2 = mul_round(x, x, 62);
        t = UNIT_Q62;
        for (int k = 7; k >= 1; k--)
            t = UNIT_Q62 - mul_round(x2, t, 62) / 64'((2 * k) * (2 * k + 1));
        s = mul_round(x, t, 62);
        t = UNIT_Q62;
        for (int k = 8; k >= 1; k--)
            t = UNIT_Q62 - mul_round(x2, t, 62) / 64'((2 * k - 1) * (2 * k));
        c = t;
    endtask

    task automatic phase_sincos(input logic [39:0] p, output logic [63:0] s,
                                output logic sn, output logic [63:0] c, output logic cn);
        logic [1:0]  q;
        logic [39:0] f;
        logic [63:0] st;
        logic [63:0] ct;
        q = p[39:38];
        f = {2'b00, p[37:0]};
        if (f <= EIGHTH)
            eighth_sincos(64'(f), st, ct);
        else
            eighth_sincos(64'(QUARTER - f), ct, st);
        case (q)
            2'd0: begin s = st; sn = 0; c = ct; cn = 0; end
            2'd1: begin s = ct; sn = 0; c = st; cn = 1; end
            2'd2: begin s = st; sn = 1; c = ct; cn = 1; end
            default: begin s = ct; sn = 1; c = st; cn = 0; end
        endcase
    endtask

    function automatic logic [33:0] to_mm(input logic [63:0] q20, input logic neg);
        logic [63:0] mm;
        mm = (q20 + (64'd1 << 19)) >> 20;
        if (mm > SAT_MM)
            mm = SAT_MM;
        return 34'(neg ? -mm : mm);
    endfunction

    task automatic predict_point(input logic signed [30:0] lat, input logic signed [31:0] lon,
                                 input logic signed [27:0] alt, output ecef_pt_t pt);
        logic [63:0] sl, cl, so, co, w, y, t, n, h, r, rz, m;
        logic        sln, cln, son, con;
        phase_sincos(angle_phase(64'(lat)), sl, sln, cl, cln);
        phase_sincos(angle_phase(64'(lon)), so, son, co, con);
        w = UNIT_Q62 - mul_round(ECC_SQ, mul_round(sl, sl, 62), 62);
        y = UNIT_Q62;
        for (int i = 0; i < 5; i++) begin
            t = 3 * UNIT_Q62 - mul_round(w, mul_round(y, y, 62), 62);
            y = mul_round(y, t, 63);
        end
        n = mul_round(AXIS_MM, y, 42);
        h = 64'(signed'(alt)) << 20;
        r = n + h;
        rz = mul_round(n, UNIT_Q62 - ECC_SQ, 62) + h;
        m = mul_round(r, cl, 62);
        pt.x = to_mm(mul_round(m, co, 62), cln != con);
        pt.y = to_mm(mul_round(m, so, 62), cln != son);
        pt.z = to_mm(mul_round(rz, sl, 62), sln);
    endtask

    assign pending = expected_points.size();

    always @(posedge clk or negedge rst_n)
    begin
        ecef_pt_t pt;
        ecef_pt_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_point(latitude, longitude, altitude, pt);
                expected_points.insert(expected_points.size(), pt);
            end
            if (done)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                             ecef_x, ecef_y, ecef_z);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (want.x !== ecef_x || want.y !== ecef_y || want.z !== ecef_z)
                    begin
                        $display("%0t: mismatch expected x=%0d y=%0d z=%0d %s x=%0d y=%0d z=%0d",
                                 $time, $signed(want.x), $signed(want.y), $signed(want.z),
                                 "actual", ecef_x, ecef_y, ecef_z);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: request stimulus and verdict for geodetic_to_ecef
// depends on geodetic_to_ecef (rtl) and geodetic_to_ecef_checker
module tb;

    localparam int LATENCY     = 89;
    localparam int STALL_LIMIT = 2000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [30:0] latitude;
    logic signed [31:0] longitude;
    logic signed [27:0] altitude;
    logic               done;
    logic signed [33:0] ecef_x;
    logic signed [33:0] ecef_y;
    logic signed [33:0] ecef_z;
    int                 fail_count;
    int                 pending;
    int                 quiet_cycles;

    geodetic_to_ecef i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .latitude(latitude), .longitude(longitude), .altitude(altitude),
        .done(done), .ecef_x(ecef_x), .ecef_y(ecef_y), .ecef_z(ecef_z)
    );

    geodetic_to_ecef_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .latitude(latitude), .longitude(longitude), .altitude(altitude),
        .done(done), .ecef_x(ecef_x), .ecef_y(ecef_y), .ecef_z(ecef_z),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // one request; random idle cycles first unless idling is off
    task automatic send_request(input logic [30:0] lat, input logic [31:0] lon,
                                input logic [27:0] alt, input bit may_idle);
        if (may_idle)
        begin
            while ($urandom_range(99) < 23)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start     <= 1'b1;
        latitude  <= lat;
        longitude <= lon;
        altitude  <= alt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        logic [30:0] lat;
        logic [31:0] lon;
        logic [27:0] alt;
        int          sel;
        int          waited;
        rst_n        = 1'b0;
        start        = 1'b0;
        latitude     = '0;
        longitude    = '0;
        altitude     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: poles, equator, date line, extremes of every field and out of range angles
        send_request(31'sd0, 32'sd0, 28'sd0, 1);
        send_request(31'sd900000000, 32'sd0, 28'sd0, 1);
        send_request(-31'sd900000000, 32'sd0, 28'sd0, 1);
        send_request(31'sd0, 32'sd1800000000, 28'sd0, 0);
        send_request(31'sd0, -32'sd1800000000, 28'sd0, 0);
        send_request(31'sd0, 32'sd900000000, 28'sd100000000, 0);
        send_request(31'sd0, -32'sd900000000, -28'sd10000000, 0);
        send_request(31'sd450000000, 32'sd450000000, 28'sd0, 1);
        send_request(31'h3FFF_FFFF, 32'h7FFF_FFFF, 28'h7FF_FFFF, 1);
        send_request(31'h4000_0000, 32'h8000_0000, 28'h800_0000, 0);
        send_request(31'h7FFF_FFFF, 32'hFFFF_FFFF, 28'hFFF_FFFF, 0);
        send_request(31'sd0, 32'sd0, 28'h7FF_FFFF, 0);
        send_request(31'sd0, 32'sd0, 28'h800_0000, 1);
        send_request(31'sd1000000000, 32'sd2100000000, 28'sd5000, 1);
        send_request(31'sd225000000, 32'sd675000000, 28'sd1, 0);
        send_request(31'sd0, 32'sd450000000, 28'sd0, 0);

        // random; the middle stretch runs with no idling at all
        for (int i = 0; i < 1700; i++)
        begin
            sel = $urandom_range(9);
            if (sel < 7)
            begin
                lat = 31'($signed($urandom_range(1800000000)) - 900000000);
                lon = $urandom_range(32'd3600000000) - 32'd1800000000;
                alt = 28'($signed($urandom_range(110000000)) - 10000000);
            end
            else
            begin
                lat = 31'($urandom);
                lon = $urandom;
                alt = 28'($urandom);
            end
            send_request(lat, lon, alt, !(i >= 600 && i < 900));
        end
        start <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 20 * LATENCY)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
